// ----- hw/rtl/gcws_pkg.sv -----
package gcws_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int REG_BITS       = 16;
	localparam int REG_IDX_BITS   = 2;
	localparam int SQ_BITS        = 2 * REG_BITS;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_GAP_THRESHOLD = 2'd0,
		REG_MIN_WIDTH     = 2'd1,
		REG_MAX_WIDTH     = 2'd2,
		REG_ORIGIN_LIMIT  = 2'd3
	} reg_idx_t;

	localparam logic [REG_BITS-1:0] GAP_RESET    = 16'd250;
	localparam logic [REG_BITS-1:0] MIN_RESET    = 16'd50;
	localparam logic [REG_BITS-1:0] MAX_RESET    = 16'd650;
	localparam logic [REG_BITS-1:0] ORIGIN_RESET = 16'd100;

	localparam logic [SQ_BITS-1:0] GAP_SQ_RESET = SQ_BITS'(250 * 250);
	localparam logic [SQ_BITS-1:0] MIN_SQ_RESET = SQ_BITS'(50 * 50);
	localparam logic [SQ_BITS-1:0] MAX_SQ_RESET = SQ_BITS'(650 * 650);

	function automatic logic [SQ_BITS-1:0] square_reg(input logic [REG_BITS-1:0] v);
		return SQ_BITS'(v) * SQ_BITS'(v);
	endfunction

endpackage

// ----- hw/rtl/gcws_dist2.sv -----
module gcws_dist2
	import gcws_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic signed [COORD_BITS-1:0] a_x,
	input  logic signed [COORD_BITS-1:0] a_y,
	input  logic signed [COORD_BITS-1:0] b_x,
	input  logic signed [COORD_BITS-1:0] b_y,
	output logic        [2*COORD_BITS+2:0] d2
);

	localparam int DW = COORD_BITS + 1;
	localparam int SW = 2 * DW;

	logic signed [DW-1:0] dx;
	logic signed [DW-1:0] dy;
	logic        [DW-1:0] mx;
	logic        [DW-1:0] my;
	logic        [SW-1:0] sx;
	logic        [SW-1:0] sy;

	always_comb begin
		dx = DW'(a_x) - DW'(b_x);
		dy = DW'(a_y) - DW'(b_y);
		mx = dx[DW-1] ? (~dx + DW'(1)) : dx;
		my = dy[DW-1] ? (~dy + DW'(1)) : dy;
		sx = SW'(mx) * SW'(mx);
		sy = SW'(my) * SW'(my);
		d2 = (SW+1)'(sx) + (SW+1)'(sy);
	end

endmodule

// ----- hw/rtl/gap_cluster_width_segmenter.sv -----
// Channel   | Handshake                    | Payload
// ----------+------------------------------+-----------------------------
// point in  | in_valid / in_stall          | point_x, point_y, scan_end
// center out| out_valid / out_stall        | center_x, center_y
// config    | cfg_we (no wait)             | cfg_index, cfg_data
//
// One point per cycle sustained while in_stall is low; a point is held in the
// input register, then its center goes to the output register. Between the
// two lies one squared-distance pass (subtract, square, add, compare).
// Reset clears the input and output valid flags, the cluster state and sets
// registers to their defaults. in_stall rises only when a point that emits a
// center finds the output register full and not being taken.
module gap_cluster_width_segmenter
	import gcws_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [REG_IDX_BITS-1:0]       cfg_index,
	input  logic [REG_BITS-1:0]           cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_BITS-1:0]  point_x,
	input  logic signed [COORD_BITS-1:0]  point_y,
	input  logic                          scan_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [COORD_BITS-1:0]  center_x,
	output logic signed [COORD_BITS-1:0]  center_y
);

	localparam int D2W  = 2 * COORD_BITS + 3;
	localparam int LW   = COORD_BITS + REG_BITS;
	localparam int CMPW = (D2W > SQ_BITS) ? D2W : SQ_BITS;

	logic [SQ_BITS-1:0]  gap_sq_q;
	logic [SQ_BITS-1:0]  min_sq_q;
	logic [SQ_BITS-1:0]  max_sq_q;
	logic [REG_BITS-1:0] origin_q;

	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] x_s1;
	logic signed [COORD_BITS-1:0] y_s1;
	logic                         last_s1;

	logic                         open_q;
	logic signed [COORD_BITS-1:0] prev_x_q;
	logic signed [COORD_BITS-1:0] prev_y_q;
	logic signed [COORD_BITS-1:0] start_x_q;
	logic signed [COORD_BITS-1:0] start_y_q;

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] center_x_q;
	logic signed [COORD_BITS-1:0] center_y_q;

	logic [D2W-1:0]        gap_d2;
	logic [D2W-1:0]        width_d2;
	logic [COORD_BITS-1:0] abs_x;
	logic [COORD_BITS-1:0] abs_y;
	logic                  pt_ok;
	logic                  split;
	logic                  width_ok;
	logic                  emit;
	logic                  out_free;
	logic                  s1_go;
	logic                  accept;
	logic signed [COORD_BITS:0] sum_x;
	logic signed [COORD_BITS:0] sum_y;

	gcws_dist2 #(.COORD_BITS(COORD_BITS)) u_gap_dist (
		.a_x (x_s1),
		.a_y (y_s1),
		.b_x (prev_x_q),
		.b_y (prev_y_q),
		.d2  (gap_d2)
	);

	gcws_dist2 #(.COORD_BITS(COORD_BITS)) u_width_dist (
		.a_x (prev_x_q),
		.a_y (prev_y_q),
		.b_x (start_x_q),
		.b_y (start_y_q),
		.d2  (width_d2)
	);

	always_comb begin
		abs_x    = x_s1[COORD_BITS-1] ? (~x_s1 + COORD_BITS'(1)) : x_s1;
		abs_y    = y_s1[COORD_BITS-1] ? (~y_s1 + COORD_BITS'(1)) : y_s1;
		pt_ok    = !((LW'(abs_x) < LW'(origin_q)) && (LW'(abs_y) < LW'(origin_q)));
		split    = open_q && (CMPW'(gap_d2) > CMPW'(gap_sq_q));
		width_ok = (CMPW'(min_sq_q) < CMPW'(width_d2)) &&
			(CMPW'(width_d2) < CMPW'(max_sq_q));
		emit     = pt_ok && split && width_ok;
		out_free = !out_valid_q || !out_stall;
		s1_go    = valid_s1 && (!emit || out_free);
		in_stall = valid_s1 && !s1_go;
		accept   = in_valid && !in_stall;
		sum_x    = (COORD_BITS+1)'(start_x_q) + (COORD_BITS+1)'(prev_x_q);
		sum_y    = (COORD_BITS+1)'(start_y_q) + (COORD_BITS+1)'(prev_y_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_sq_q <= GAP_SQ_RESET;
			min_sq_q <= MIN_SQ_RESET;
			max_sq_q <= MAX_SQ_RESET;
			origin_q <= ORIGIN_RESET;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_GAP_THRESHOLD: gap_sq_q <= square_reg(cfg_data);
				REG_MIN_WIDTH:     min_sq_q <= square_reg(cfg_data);
				REG_MAX_WIDTH:     max_sq_q <= square_reg(cfg_data);
				REG_ORIGIN_LIMIT:  origin_q <= cfg_data;
				default:           origin_q <= origin_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_s1    <= point_x;
			y_s1    <= point_y;
			last_s1 <= scan_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q    <= 1'b0;
			prev_x_q  <= '0;
			prev_y_q  <= '0;
			start_x_q <= '0;
			start_y_q <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				open_q    <= 1'b0;
				prev_x_q  <= '0;
				prev_y_q  <= '0;
				start_x_q <= '0;
				start_y_q <= '0;
			end else if (pt_ok) begin
				if (!open_q || split) begin
					start_x_q <= x_s1;
					start_y_q <= y_s1;
				end
				open_q   <= 1'b1;
				prev_x_q <= x_s1;
				prev_y_q <= y_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && emit) begin
			center_x_q <= sum_x[COORD_BITS:1];
			center_y_q <= sum_y[COORD_BITS:1];
		end
	end

	assign out_valid = out_valid_q;
	assign center_x  = center_x_q;
	assign center_y  = center_y_q;

endmodule

// ----- test/gcws_checker.sv -----
`timescale 1ns / 100ps

module gcws_checker
	import gcws_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [REG_IDX_BITS-1:0]      cfg_index,
	input  logic [REG_BITS-1:0]          cfg_data,
	input  logic                         in_valid,
	input  logic                         in_stall,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic                         scan_end,
	input  logic                         out_valid,
	input  logic                         out_stall,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	output int                           mismatches,
	output int                           centers_pending
);

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x;
		logic signed [COORD_BITS-1:0] y;
	} center_t;

	center_t centers_due[$];

	logic [REG_BITS-1:0] gap_mm;
	logic [REG_BITS-1:0] min_mm;
	logic [REG_BITS-1:0] max_mm;
	logic [REG_BITS-1:0] origin_mm;

	bit                           cluster_open;
	logic signed [COORD_BITS-1:0] first_x;
	logic signed [COORD_BITS-1:0] first_y;
	logic signed [COORD_BITS-1:0] last_x;
	logic signed [COORD_BITS-1:0] last_y;

	function automatic longint coord_mag(input longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint unsigned span_sq(input longint ax, ay, bx, by);
		longint dx;
		longint dy;
		dx = coord_mag(ax - bx);
		dy = coord_mag(ay - by);
		return dx * dx + dy * dy;
	endfunction

	function automatic logic signed [COORD_BITS-1:0] floor_mid(
		input logic signed [COORD_BITS-1:0] a,
		input logic signed [COORD_BITS-1:0] b
	);
		logic signed [COORD_BITS:0] s;
		s = a + b;
		return s[COORD_BITS:1];
	endfunction

	task automatic clear_cluster();
		cluster_open = 0;
		first_x = '0;
		first_y = '0;
		last_x = '0;
		last_y = '0;
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic absorb_point(input longint x, input longint y, input logic end_of_scan);
		longint          lim;
		longint unsigned gap_sq;
		longint unsigned lo_sq;
		longint unsigned hi_sq;
		longint unsigned width_sq;
		lim = longint'(origin_mm);
		gap_sq = 64'(gap_mm) * 64'(gap_mm);
		lo_sq = 64'(min_mm) * 64'(min_mm);
		hi_sq = 64'(max_mm) * 64'(max_mm);
		if (!(coord_mag(x) < lim && coord_mag(y) < lim)) begin
			if (!cluster_open) begin
				cluster_open = 1;
				first_x = COORD_BITS'(x);
				first_y = COORD_BITS'(y);
			end else if (span_sq(x, y, last_x, last_y) > gap_sq) begin
				width_sq = span_sq(last_x, last_y, first_x, first_y);
				if (lo_sq < width_sq && width_sq < hi_sq)
					centers_due.push_back('{floor_mid(first_x, last_x),
						floor_mid(first_y, last_y)});
				first_x = COORD_BITS'(x);
				first_y = COORD_BITS'(y);
			end
			last_x = COORD_BITS'(x);
			last_y = COORD_BITS'(y);
		end
		if (end_of_scan)
			clear_cluster();
	endtask

	task automatic check_center();
		center_t want;
		if (centers_due.size() == 0) begin
			report_mismatch($sformatf("center (%0d, %0d) with none pending", center_x, center_y));
			return;
		end
		want = centers_due.pop_front();
		if (center_x !== want.x)
			report_mismatch($sformatf("center_x got %0d want %0d", center_x, want.x));
		if (center_y !== want.y)
			report_mismatch($sformatf("center_y got %0d want %0d", center_y, want.y));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_mm = GAP_RESET;
			min_mm = MIN_RESET;
			max_mm = MAX_RESET;
			origin_mm = ORIGIN_RESET;
			clear_cluster();
			centers_due.delete();
			mismatches = 0;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_GAP_THRESHOLD: gap_mm = cfg_data;
					REG_MIN_WIDTH:     min_mm = cfg_data;
					REG_MAX_WIDTH:     max_mm = cfg_data;
					REG_ORIGIN_LIMIT:  origin_mm = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall)
				check_center();
			if (in_valid && !in_stall)
				absorb_point(longint'(point_x), longint'(point_y), scan_end);
		end
		centers_pending = centers_due.size();
	end

endmodule

// ----- test/tb_gap_cluster_width_segmenter.sv -----
`timescale 1ns / 100ps

module tb_gap_cluster_width_segmenter;
	import gcws_pkg::*;

	localparam int CW           = COORD_BITS_DEF;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_CYCLES  = 300;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [REG_IDX_BITS-1:0] cfg_index = REG_GAP_THRESHOLD;
	logic [REG_BITS-1:0]     cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic signed [CW-1:0]    point_x = '0;
	logic signed [CW-1:0]    point_y = '0;
	logic                    scan_end = 1'b0;
	logic                    out_stall = 1'b0;
	logic                    in_stall;
	logic                    out_valid;
	logic signed [CW-1:0]    center_x;
	logic signed [CW-1:0]    center_y;

	int mismatches;
	int centers_pending;
	int idle_pct = 14;
	bit hold_off_req = 0;
	int cycles = 0;

	logic [REG_BITS-1:0] gap_mm = GAP_RESET;
	logic [REG_BITS-1:0] origin_mm = ORIGIN_RESET;

	gap_cluster_width_segmenter #(.COORD_BITS(CW)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.point_x   (point_x),
		.point_y   (point_y),
		.scan_end  (scan_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.center_x  (center_x),
		.center_y  (center_y)
	);

	gcws_checker #(.COORD_BITS(CW)) center_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.point_x         (point_x),
		.point_y         (point_y),
		.scan_end        (scan_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.center_x        (center_x),
		.center_y        (center_y),
		.mismatches      (mismatches),
		.centers_pending (centers_pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL gap_cluster_width_segmenter");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_off_req = 0;
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < idle_pct);
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [REG_BITS-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		if (idx == REG_GAP_THRESHOLD)
			gap_mm = v;
		if (idx == REG_ORIGIN_LIMIT)
			origin_mm = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [REG_BITS-1:0] gap, mn, mx, org);
		write_reg(REG_GAP_THRESHOLD, gap);
		write_reg(REG_MIN_WIDTH, mn);
		write_reg(REG_MAX_WIDTH, mx);
		write_reg(REG_ORIGIN_LIMIT, org);
	endtask

	task automatic send_point(input logic signed [CW-1:0] x, y, input logic end_of_scan);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		point_x <= x;
		point_y <= y;
		scan_end <= end_of_scan;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
	endtask

	// hold the input until every center has come out, then let the pipe empty
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (centers_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic send_cluster(input int n);
		int bx;
		int by;
		int step;
		step = int'(gap_mm) / 2;
		bx = int'($urandom_range(32000)) - 16000;
		by = int'($urandom_range(32000)) - 16000;
		for (int i = 0; i < n; i++) begin
			send_point(CW'(bx), CW'(by), $urandom_range(99) < 3);
			bx += int'($urandom_range(2 * step)) - step;
			by += int'($urandom_range(2 * step)) - step;
		end
	endtask

	task automatic run_phase(input int n_items);
		int sent;
		int pick;
		int n;
		int o;
		sent = 0;
		o = int'(origin_mm);
		while (sent < n_items) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				n = $urandom_range(1, 6);
				send_cluster(n);
				sent += n;
			end else if (pick < 85) begin
				send_point(CW'($urandom), CW'($urandom), $urandom_range(99) < 5);
				sent++;
			end else if (pick < 95) begin
				send_point(CW'(int'($urandom_range(2 * o)) - o),
					CW'(int'($urandom_range(2 * o)) - o), $urandom_range(99) < 5);
				sent++;
			end else begin
				send_point(CW'(int'($urandom_range(60000)) - 30000),
					CW'(int'($urandom_range(60000)) - 30000), 1'b1);
				sent++;
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: skips, gap and width boundaries, scan ends
		send_point(10, -20, 0);
		send_point(99, -99, 0);
		send_point(100, 0, 0);
		send_point(-100, 5, 0);
		send_point(-300, 5, 0);
		send_point(2000, 0, 0);
		send_point(0, 0, 0);
		send_point(2010, 0, 0);
		send_point(-1001, -3, 0);
		send_point(-1200, -100, 0);
		send_point(32767, 32767, 0);
		send_point(3000, 0, 0);
		send_point(3200, 0, 0);
		send_point(4000, 0, 1);
		send_point(4100, 0, 0);
		send_point(5, 5, 1);
		send_point(10000, 0, 0);
		send_point(10250, 0, 0);
		send_point(10650, 0, 0);
		send_point(20000, 0, 0);
		send_point(20050, 0, 0);
		send_point(-20000, -20000, 0);
		send_point(-20000, -19949, 0);
		send_point(0, -32768, 1);
		drain();

		configure(16'd0, 16'd0, 16'hFFFF, 16'd0);
		send_point(0, 0, 0);
		send_point(0, 0, 0);
		send_point(1, 0, 1);
		drain();
		configure(16'hFFFF, 16'd0, 16'hFFFF, 16'd0);
		send_point(-32768, -32768, 0);
		send_point(0, -32768, 0);
		send_point(32767, 32767, 1);
		drain();
		write_reg(REG_ORIGIN_LIMIT, 16'hFFFF);
		send_point(-32768, 32767, 0);
		send_point(32767, -32768, 1);
		drain();

		configure(GAP_RESET, MIN_RESET, MAX_RESET, ORIGIN_RESET);
		run_phase(80);
		hold_off_req = 1;
		for (int i = 0; i < 20; i++)
			send_cluster(2);
		drain();

		configure(16'd1000, 16'd200, 16'd3000, 16'd500);
		idle_pct = 0;
		run_phase(80);
		drain();
		idle_pct = 14;

		configure(16'd3000, 16'd0, 16'hFFFF, 16'd0);
		run_phase(40);
		drain();
		run_phase(40);
		drain();

		begin
			logic [REG_BITS-1:0] g;
			logic [REG_BITS-1:0] mn;
			g = REG_BITS'($urandom_range(100, 4000));
			mn = REG_BITS'($urandom_range(0, g));
			configure(g, mn, REG_BITS'($urandom_range(mn + g, 65535)),
				REG_BITS'($urandom_range(0, 2000)));
		end
		run_phase(80);
		drain();

		configure(16'd60, 16'd10, 16'd200, 16'd30);
		run_phase(80);
		drain();

		if (mismatches == 0 && centers_pending == 0)
			$display("PASS gap_cluster_width_segmenter");
		else
			$display("FAIL gap_cluster_width_segmenter");
		$finish;
	end

endmodule
